[rtl/csd_pkg.sv]
package csd_pkg;

    localparam int unsigned BYTE_W    = 8;
    localparam int unsigned WORD_W    = 32;
    localparam int unsigned NUM_WORDS = 6;
    localparam int unsigned COUNT_W   = 9;
    localparam int unsigned LEN_W     = 5;

    // Bytes of a point payload that land in words; the next one is the relative byte.
    localparam logic [COUNT_W-1:0] POINT_WORD_BYTES = 9'd24;
    // Header bytes of the tool command: index, subcommand, length.
    localparam logic [COUNT_W-1:0] TOOL_HDR_BYTES   = 9'd3;

    localparam logic [BYTE_W-1:0] ID_QUEUE_POINT = 8'd129;
    localparam logic [BYTE_W-1:0] ID_TOOL        = 8'd136;
    localparam logic [BYTE_W-1:0] ID_POINT_DDA   = 8'd139;
    localparam logic [BYTE_W-1:0] ID_POINT_EXT   = 8'd140;
    localparam logic [BYTE_W-1:0] ID_POINT_NEW   = 8'd142;

    localparam logic STATUS_OK      = 1'b0;
    localparam logic STATUS_UNKNOWN = 1'b1;

    typedef enum logic [1:0] {
        PH_ID,
        PH_FIXED,
        PH_TOOLHDR,
        PH_TOOLPAY
    } phase_t;

    typedef enum logic [1:0] {
        KIND_UNKNOWN,
        KIND_FIXED,
        KIND_TOOL
    } kind_t;

    typedef struct packed {
        kind_t            kind;
        logic [LEN_W-1:0] len;
    } id_info_t;

    typedef struct packed {
        logic [BYTE_W-1:0]                  command_id;
        logic                               status;
        logic [COUNT_W-1:0]                 payload_count;
        logic [NUM_WORDS-1:0][WORD_W-1:0]   words;
        logic [BYTE_W-1:0]                  relative_flags;
    } result_t;

    // Payload length table for the known command ids.
    function automatic id_info_t classify(input logic [BYTE_W-1:0] id);
        id_info_t info;
        info.kind = KIND_FIXED;
        info.len  = '0;
        if (id <= 8'd22 || id == 8'd25 || id == 8'd112 || id == 8'd201 ||
            (id >= 8'd203 && id <= 8'd215)) begin
            info.kind = KIND_FIXED;
        end else begin
            unique case (id)
                8'd129:  info.len = 5'd16;
                8'd130:  info.len = 5'd12;
                8'd131:  info.len = 5'd7;
                8'd132:  info.len = 5'd7;
                8'd133:  info.len = 5'd4;
                8'd134:  info.len = 5'd1;
                8'd135:  info.len = 5'd5;
                8'd136:  info.kind = KIND_TOOL;
                8'd137:  info.len = 5'd1;
                8'd138:  info.len = 5'd2;
                8'd139:  info.len = 5'd24;
                8'd140:  info.len = 5'd20;
                8'd141:  info.len = 5'd5;
                8'd142:  info.len = 5'd25;
                8'd143:  info.len = 5'd1;
                8'd144:  info.len = 5'd1;
                default: info.kind = KIND_UNKNOWN;
            endcase
        end
        return info;
    endfunction

    function automatic logic is_point(input logic [BYTE_W-1:0] id);
        return id == ID_QUEUE_POINT || id == ID_POINT_DDA ||
               id == ID_POINT_EXT || id == ID_POINT_NEW;
    endfunction

endpackage

[rtl/csd_parser.sv]
module csd_parser (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          in_valid,
    input  logic [csd_pkg::BYTE_W-1:0]    in_byte,
    output logic                          res_valid,
    output csd_pkg::result_t              res
);

    csd_pkg::phase_t                                        phase_reg, phase_next;
    logic [csd_pkg::BYTE_W-1:0]                             id_reg, id_next;
    logic [csd_pkg::BYTE_W-1:0]                             remaining_reg, remaining_next;
    logic [csd_pkg::COUNT_W-1:0]                            taken_reg, taken_next;
    logic [csd_pkg::NUM_WORDS-1:0][csd_pkg::WORD_W-1:0]     words_reg, words_next;
    logic [csd_pkg::BYTE_W-1:0]                             rel_reg, rel_next;
    logic [csd_pkg::BYTE_W-1:0]                             sub_len_reg, sub_len_next;

    csd_pkg::id_info_t          info;
    logic                       emit;
    logic                       status;
    logic [csd_pkg::COUNT_W-1:0] pay_idx;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg     <= csd_pkg::PH_ID;
            remaining_reg <= '0;
            taken_reg     <= '0;
        end else begin
            phase_reg     <= phase_next;
            remaining_reg <= remaining_next;
            taken_reg     <= taken_next;
        end
    end

    always_ff @(posedge aclk) begin
        id_reg      <= id_next;
        words_reg   <= words_next;
        rel_reg     <= rel_next;
        sub_len_reg <= sub_len_next;
    end

    always_comb begin
        phase_next     = phase_reg;
        id_next        = id_reg;
        remaining_next = remaining_reg;
        taken_next     = taken_reg;
        words_next     = words_reg;
        rel_next       = rel_reg;
        sub_len_next   = sub_len_reg;
        emit           = 1'b0;
        status         = csd_pkg::STATUS_OK;
        info           = csd_pkg::classify(in_byte);
        pay_idx        = taken_reg - csd_pkg::TOOL_HDR_BYTES;

        if (in_valid) begin
            unique case (phase_reg)
                csd_pkg::PH_ID: begin
                    id_next      = in_byte;
                    taken_next   = '0;
                    words_next   = '0;
                    rel_next     = '0;
                    sub_len_next = '0;
                    unique case (info.kind)
                        csd_pkg::KIND_UNKNOWN: begin
                            emit   = 1'b1;
                            status = csd_pkg::STATUS_UNKNOWN;
                        end
                        csd_pkg::KIND_TOOL: begin
                            phase_next     = csd_pkg::PH_TOOLHDR;
                            remaining_next = 8'(csd_pkg::TOOL_HDR_BYTES);
                        end
                        default: begin
                            if (info.len == '0) begin
                                emit = 1'b1;
                            end else begin
                                phase_next     = csd_pkg::PH_FIXED;
                                remaining_next = 8'(info.len);
                            end
                        end
                    endcase
                end
                csd_pkg::PH_FIXED: begin
                    if (csd_pkg::is_point(id_reg)) begin
                        if (taken_reg < csd_pkg::POINT_WORD_BYTES) begin
                            for (int w = 0; w < csd_pkg::NUM_WORDS; w++) begin
                                if (taken_reg[4:2] == 3'(w)) begin
                                    words_next[w] = words_reg[w] |
                                        (32'(in_byte) << {taken_reg[1:0], 3'b000});
                                end
                            end
                        end else begin
                            rel_next = in_byte;
                        end
                    end
                    taken_next     = taken_reg + 9'd1;
                    remaining_next = remaining_reg - 8'd1;
                    emit           = (remaining_next == '0);
                end
                csd_pkg::PH_TOOLHDR: begin
                    if (taken_reg == 9'd0) begin
                        words_next[0] = 32'(in_byte);
                    end else if (taken_reg == 9'd1) begin
                        words_next[1] = 32'(in_byte);
                    end else begin
                        sub_len_next = in_byte;
                    end
                    taken_next = taken_reg + 9'd1;
                    if (taken_next >= csd_pkg::TOOL_HDR_BYTES) begin
                        if (sub_len_next == '0) begin
                            emit = 1'b1;
                        end else begin
                            phase_next     = csd_pkg::PH_TOOLPAY;
                            remaining_next = sub_len_next;
                        end
                    end
                end
                default: begin
                    // Only the first two payload bytes form the subcommand value.
                    if (pay_idx == 9'd0) begin
                        words_next[2] = 32'(in_byte);
                    end else if (pay_idx == 9'd1) begin
                        words_next[2] = words_reg[2] | (32'(in_byte) << 8);
                    end
                    taken_next     = taken_reg + 9'd1;
                    remaining_next = remaining_reg - 8'd1;
                    emit           = (remaining_next == '0);
                end
            endcase
        end

        if (emit) begin
            phase_next     = csd_pkg::PH_ID;
            remaining_next = '0;
        end

        res_valid          = emit;
        res.command_id     = id_next;
        res.status         = status;
        res.payload_count  = taken_next;
        res.words          = words_next;
        res.relative_flags = rel_next;
    end

`ifndef NO_ASSERTIONS
    a_idle_nothing_left: assert property (@(posedge aclk) disable iff (!aresetn)
        phase_reg == csd_pkg::PH_ID |-> remaining_reg == '0)
        else $error("bytes pending while waiting for a command id");

    a_fixed_pending: assert property (@(posedge aclk) disable iff (!aresetn)
        phase_reg == csd_pkg::PH_FIXED |-> remaining_reg != '0)
        else $error("fixed payload phase with nothing left to take");

    a_tool_header_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        phase_reg == csd_pkg::PH_TOOLHDR |->
            (taken_reg < csd_pkg::TOOL_HDR_BYTES &&
             remaining_reg == 8'(csd_pkg::TOOL_HDR_BYTES)))
        else $error("tool header count out of step");

    a_tool_payload_sum: assert property (@(posedge aclk) disable iff (!aresetn)
        phase_reg == csd_pkg::PH_TOOLPAY |->
            10'(taken_reg) + 10'(remaining_reg) ==
            10'(sub_len_reg) + 10'(csd_pkg::TOOL_HDR_BYTES))
        else $error("tool payload count does not match its length byte");

    a_unknown_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        res_valid && res.status == csd_pkg::STATUS_UNKNOWN |->
            res.payload_count == '0 && res.words == '0 && res.relative_flags == '0)
        else $error("unknown-id result carries payload data");
`endif

endmodule

[rtl/command_stream_deframer_top.sv]
// Command stream deframer. Bytes of a printer command stream enter one per
// transaction on the s_ channel; the first byte of each command is its id and
// a fixed length table (or, for the tool command, its length byte) tells how
// many payload bytes follow. One result transaction leaves on the m_ channel
// per command: on the id byte itself for an unknown id (m_tuser high, the id
// in command_id and every other data field zero) or a zero-length command,
// otherwise on the last payload byte. Point and position commands are split
// into little-endian signed 32-bit words plus the relative-axes byte of the
// new-point command; the tool command yields index, subcommand and a 16-bit
// subcommand value taken from the first two payload bytes. Words a command
// does not fill read as zero. Every byte is parsed in the cycle it is taken,
// so the block accepts one byte per clock cycle unless held by backpressure,
// and a result appears on the m_ side in the cycle after its last byte. The
// single output register decides the rate under backpressure: a new byte is
// taken whenever that register is empty or is being emptied in the same cycle.
module command_stream_deframer_top (
    input  logic         aclk,
    input  logic         aresetn,

    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [7:0]   s_tdata,   // [7:0] data_byte

    output logic         m_tvalid,
    input  logic         m_tready,
    // [7:0] command_id, [16:8] payload_count, [48:17] word_zero,
    // [80:49] word_one, [112:81] word_two, [144:113] word_three,
    // [176:145] word_four, [208:177] word_five, [216:209] relative_flags,
    // [223:217] zero.
    output logic [223:0] m_tdata,
    output logic         m_tuser    // [0] status: 0 decoded, 1 unknown command id
);

    logic              s_accept;
    logic              res_valid;
    csd_pkg::result_t  res;
    logic              m_valid_reg, m_valid_next;
    csd_pkg::result_t  m_res_reg, m_res_next;

    // The output register can take a new result when it is empty or drains now.
    assign s_tready = !m_valid_reg || m_tready;
    assign s_accept = s_tvalid && s_tready;

    csd_parser u_parser (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_accept),
        .in_byte   (s_tdata),
        .res_valid (res_valid),
        .res       (res)
    );

    always_comb begin
        m_valid_next = m_valid_reg;
        m_res_next   = m_res_reg;
        if (m_valid_reg && m_tready) begin
            m_valid_next = 1'b0;
        end
        if (res_valid) begin
            m_valid_next = 1'b1;
            m_res_next   = res;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        m_res_reg <= m_res_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tuser  = m_res_reg.status;
    assign m_tdata  = {7'b0,
                       m_res_reg.relative_flags,
                       m_res_reg.words[5],
                       m_res_reg.words[4],
                       m_res_reg.words[3],
                       m_res_reg.words[2],
                       m_res_reg.words[1],
                       m_res_reg.words[0],
                       m_res_reg.payload_count,
                       m_res_reg.command_id};

`ifndef NO_ASSERTIONS
    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        res_valid |-> !m_valid_reg || m_tready)
        else $error("result produced while the output register is held");

    a_result_follows_byte: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_accept |=> !(m_tvalid && !$past(m_tvalid)))
        else $error("result appeared without an accepted byte");

    a_zero_pad: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tdata[223:217] == '0)
        else $error("padding bits of the result are not zero");
`endif

endmodule
